@@ rtl/wsrx_pkg.sv @@
// WebSocket receive/unmask package: result type, kind codes, widths.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wsrx_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int KEY_W  = 32;

  localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADOP    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNMASKED = 2'd3;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              fin_flag;
    logic              is_continuation;
  } result_t;

endpackage

@@ rtl/wsrx_parser.sv @@
// Frame header parser and payload unmasker, one byte per transfer.
// Depends on wsrx_pkg.
`timescale 1ns / 1ps

module wsrx_parser #(
  parameter int LEN_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  logic [wsrx_pkg::BYTE_W-1:0] rx_byte,
  output logic                      res_valid,
  output wsrx_pkg::result_t         res
);

  localparam logic [2:0] PH_HDR0     = 3'd0;
  localparam logic [2:0] PH_HDR1_OK  = 3'd1;
  localparam logic [2:0] PH_HDR1_BAD = 3'd2;
  localparam logic [2:0] PH_EXT      = 3'd3;
  localparam logic [2:0] PH_KEY      = 3'd4;
  localparam logic [2:0] PH_DATA     = 3'd5;

  logic [2:0]                  phase, phase_next;
  logic [2:0]                  sub_count, sub_count_next;
  logic                        ext_is_long, ext_is_long_next;
  logic [LEN_BITS-1:0]         remaining, remaining_next;
  logic [wsrx_pkg::KEY_W-1:0]  mask_key, mask_key_next;
  logic [1:0]                  key_pos, key_pos_next;
  logic                        frame_fin, frame_fin_next;
  logic                        frame_cont, frame_cont_next;

  logic [6:0]                  len7;
  logic [3:0]                  op;
  logic [LEN_BITS-1:0]         rem_dec;
  logic [wsrx_pkg::BYTE_W-1:0] key_byte;

  assign len7    = rx_byte[6:0];
  assign op      = rx_byte[3:0];
  assign rem_dec = remaining - LEN_BITS'(1);

  always_comb begin
    case (key_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next       = phase;
    sub_count_next   = sub_count;
    ext_is_long_next = ext_is_long;
    remaining_next   = remaining;
    mask_key_next    = mask_key;
    key_pos_next     = key_pos;
    frame_fin_next   = frame_fin;
    frame_cont_next  = frame_cont;
    res_valid        = 1'b0;
    res.data_byte       = '0;
    res.kind            = wsrx_pkg::KIND_DATA;
    res.last            = 1'b1;
    res.fin_flag        = frame_fin;
    res.is_continuation = frame_cont;

    case (phase)
      PH_HDR1_BAD: begin
        res_valid           = in_fire;
        res.kind            = wsrx_pkg::KIND_BADOP;
        res.is_continuation = 1'b0;
        phase_next          = PH_HDR0;
      end
      PH_HDR1_OK: begin
        if (!rx_byte[7]) begin
          res_valid  = in_fire;
          res.kind   = wsrx_pkg::KIND_UNMASKED;
          phase_next = PH_HDR0;
        end else begin
          sub_count_next = '0;
          mask_key_next  = '0;
          if (len7 == wsrx_pkg::LEN7_EXT16 || len7 == wsrx_pkg::LEN7_EXT64) begin
            ext_is_long_next = (len7 == wsrx_pkg::LEN7_EXT64);
            remaining_next   = '0;
            phase_next       = PH_EXT;
          end else begin
            remaining_next = LEN_BITS'(len7);
            phase_next     = PH_KEY;
          end
        end
      end
      PH_EXT: begin
        remaining_next = {remaining[LEN_BITS-9:0], rx_byte};
        if (sub_count >= (ext_is_long ? 3'd7 : 3'd1)) begin
          sub_count_next = '0;
          phase_next     = PH_KEY;
        end else begin
          sub_count_next = sub_count + 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (sub_count >= 3'd3) begin
          sub_count_next = '0;
          key_pos_next   = '0;
          if (remaining == '0) begin
            res_valid  = in_fire;
            res.kind   = wsrx_pkg::KIND_EMPTY;
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          sub_count_next = sub_count + 3'd1;
        end
      end
      PH_DATA: begin
        key_pos_next   = key_pos + 2'd1;
        remaining_next = rem_dec;
        res_valid      = in_fire;
        res.data_byte  = rx_byte ^ key_byte;
        res.last       = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        frame_fin_next  = rx_byte[7];
        frame_cont_next = (op == wsrx_pkg::OP_CONT);
        phase_next      = (op == wsrx_pkg::OP_CONT || op == wsrx_pkg::OP_TEXT) ?
                          PH_HDR1_OK : PH_HDR1_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      sub_count   <= '0;
      ext_is_long <= 1'b0;
      remaining   <= '0;
      mask_key    <= '0;
      key_pos     <= '0;
      frame_fin   <= 1'b0;
      frame_cont  <= 1'b0;
    end else if (in_fire) begin
      phase       <= phase_next;
      sub_count   <= sub_count_next;
      ext_is_long <= ext_is_long_next;
      remaining   <= remaining_next;
      mask_key    <= mask_key_next;
      key_pos     <= key_pos_next;
      frame_fin   <= frame_fin_next;
      frame_cont  <= frame_cont_next;
    end
  end

endmodule

@@ rtl/wsrx_out_buf.sv @@
// Result register with one skid entry; decouples output stalls from input.
// Depends on wsrx_pkg.
`timescale 1ns / 1ps

module wsrx_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  wsrx_pkg::result_t wr_data,
  output logic              wr_ready,
  output logic              rd_valid,
  input  logic              rd_ready,
  output wsrx_pkg::result_t rd_data
);

  logic              out_valid;
  logic              skid_valid;
  wsrx_pkg::result_t out_reg;
  wsrx_pkg::result_t skid_reg;
  logic              out_free;

  assign wr_ready = !skid_valid;
  assign rd_valid = out_valid;
  assign rd_data  = out_reg;
  assign out_free = !out_valid || rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (wr_valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (rd_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_reg <= skid_reg;
      end
    end else if (wr_valid) begin
      if (out_free) begin
        out_reg <= wr_data;
      end else begin
        skid_reg <= wr_data;
      end
    end
  end

endmodule

@@ rtl/websocket_frame_receive_unmask.sv @@
// Top level of the WebSocket frame receiver with payload unmasking.
// Depends on wsrx_pkg, wsrx_parser and wsrx_out_buf.
`timescale 1ns / 1ps

// Takes one byte per cycle while byte_ready is high and returns at most one
// result per byte: an unmasked payload byte, or a status (empty frame,
// rejected opcode, unmasked frame) from the second header or last key byte;
// no other byte gives a result. A result enters the output register on its
// byte transfer unless the output is stalled, else it waits in the skid
// entry; the parser handles each byte combinationally, bounded by the
// LEN_BITS-wide payload counter decrement and zero compare. A one-entry skid
// buffer keeps byte_ready high while a result waits, so a stalled output
// holds the input only once the output register and the skid entry are full.

module websocket_frame_receive_unmask #(
  parameter int LEN_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] data_byte,
  output logic [1:0] kind,
  output logic       last,
  output logic       fin_flag,
  output logic       is_continuation
);

  logic              in_fire;
  logic              parse_valid;
  wsrx_pkg::result_t parse_res;
  wsrx_pkg::result_t out_res;

  assign in_fire = byte_valid && byte_ready;

  wsrx_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .rx_byte  (rx_byte),
    .res_valid(parse_valid),
    .res      (parse_res)
  );

  wsrx_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(parse_valid),
    .wr_data (parse_res),
    .wr_ready(byte_ready),
    .rd_valid(res_valid),
    .rd_ready(res_ready),
    .rd_data (out_res)
  );

  assign data_byte       = out_res.data_byte;
  assign kind            = out_res.kind;
  assign last            = out_res.last;
  assign fin_flag        = out_res.fin_flag;
  assign is_continuation = out_res.is_continuation;

endmodule
